// ----- rtl/mvp_pkg.sv -----
package mvp_pkg;

    typedef logic [31:0] word_t;
    typedef logic [47:0] quot_t;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DUTY_MAX  = 255;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_SCALE = 3'd3;

    localparam logic [1:0] DIR_COAST = 2'd0;
    localparam logic [1:0] DIR_FWD   = 2'd1;
    localparam logic [1:0] DIR_REV   = 2'd2;

    localparam word_t       GAIN_P_RESET = 32'd3276800;
    localparam word_t       GAIN_I_RESET = 32'd1311;
    localparam word_t       GAIN_D_RESET = 32'd0;
    localparam logic [23:0] SCALE_RESET  = 24'hFFA51B;

    localparam logic [15:0] MS_PER_S  = 16'd1000;
    localparam word_t       INT_LIMIT = 32'd16711680;

    // magnitude plus sign back to a saturated 32-bit two's complement word
    function automatic word_t sat_mag(input logic [55:0] mag, input logic neg);
        logic big;
        big = (mag >= 56'h0000_0080_0000_00);
        if (neg)
            return big ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        else
            return big ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic word_t abs32(input word_t x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic word_t abs33(input logic [32:0] x);
        logic [32:0] n;
        n = ~x + 33'd1;
        return x[32] ? n[31:0] : x[31:0];
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic [32:0] r;
        r = {a[31], a} - {b[31], b};
        if (r[32] != r[31])
            return r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return r[31:0];
    endfunction

endpackage

// ----- rtl/motor_velocity_pid.sv -----
// Velocity PID controller for an H-bridge motor drive.
// Input item on s_*: raw encoder count, elapsed ms and target velocity (Q16.16).
// Output item on m_*: direction (0 coast, 1 forward, 2 reverse) and 8-bit duty.
// A zero target gives one coast item; a zero drive with nonzero target gives no
// item and the bridge keeps its last setting.
// Gains and the count-to-position scale are written on the cfg_* channel by
// register index; write them only while the block is idle. cfg_ready is always high.
// From acceptance to its result an item passes through seven products on a
// one-bit-per-cycle shift-add multiplier, three quotients on a
// one-bit-per-cycle restoring divider and fifteen bookkeeping steps.
// Items are handled one at a time: no new item is taken before the sequencer
// is done with the last; s_tready is high only while the sequencer waits.
// The result sits in an output register, so the next item is taken while it
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds in its last step until the register frees.
// Reset restores the default gains and clears position, error and integral.
module motor_velocity_pid (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // encoder_count[31:0], elapsed_ms[47:32], target_velocity[79:48]
    input  logic [mvp_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // direction[1:0], duty[9:2], zero fill[15:10]
    output logic [mvp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mvp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mvp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mvp_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MPOS = 5'd1;
    localparam logic [4:0] S_POS  = 5'd2;
    localparam logic [4:0] S_DIFF = 5'd3;
    localparam logic [4:0] S_LVEL = 5'd4;
    localparam logic [4:0] S_MVEL = 5'd5;
    localparam logic [4:0] S_DVL  = 5'd6;
    localparam logic [4:0] S_DVEL = 5'd7;
    localparam logic [4:0] S_VEL  = 5'd8;
    localparam logic [4:0] S_ERR  = 5'd9;
    localparam logic [4:0] S_LINT = 5'd10;
    localparam logic [4:0] S_MINT = 5'd11;
    localparam logic [4:0] S_DIL  = 5'd12;
    localparam logic [4:0] S_DINT = 5'd13;
    localparam logic [4:0] S_INT  = 5'd14;
    localparam logic [4:0] S_MDER = 5'd15;
    localparam logic [4:0] S_DDL  = 5'd16;
    localparam logic [4:0] S_DDER = 5'd17;
    localparam logic [4:0] S_DER  = 5'd18;
    localparam logic [4:0] S_MGP  = 5'd19;
    localparam logic [4:0] S_AGP  = 5'd20;
    localparam logic [4:0] S_MGI  = 5'd21;
    localparam logic [4:0] S_AGI  = 5'd22;
    localparam logic [4:0] S_MGD  = 5'd23;
    localparam logic [4:0] S_AGD  = 5'd24;
    localparam logic [4:0] S_OUT  = 5'd25;

    localparam logic [5:0] MUL_LAST = 6'(MUL_STEPS - 1);
    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

    logic [4:0]  state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    word_t       gain_p_reg, gain_p_next;
    word_t       gain_i_reg, gain_i_next;
    word_t       gain_d_reg, gain_d_next;
    logic [23:0] scale_reg, scale_next;
    word_t       last_pos_reg, last_pos_next;
    word_t       last_err_reg, last_err_next;
    word_t       integral_reg, integral_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [15:0] t_reg, t_next;
    word_t       target_reg, target_next;
    word_t       err_reg, err_next;
    word_t       der_reg, der_next;
    logic [32:0] diff_reg, diff_next;
    logic        neg_reg, neg_next;
    logic signed [50:0] sum_reg, sum_next;

    word_t       mul_a_reg, mul_a_next;
    word_t       mul_hi_reg, mul_hi_next;
    word_t       mul_lo_reg, mul_lo_next;
    logic [15:0] div_d_reg, div_d_next;
    logic [15:0] div_rem_reg, div_rem_next;
    quot_t       div_quo_reg, div_quo_next;

    logic [32:0] mul_sum;
    logic [63:0] mul_prod;
    logic [16:0] div_r2;
    logic [17:0] div_sub;
    logic        div_ge;

    logic [23:0] scale_abs;
    logic [25:0] int_q;
    logic signed [27:0] int_lim, int_base, int_add, int_acc, int_clamped;
    logic signed [50:0] term;
    logic [50:0] sum_mag;
    logic [33:0] pwm_mag;
    logic        pwm_nz;
    logic [7:0]  duty_val;
    logic        emit;
    logic [1:0]  out_dir;
    logic        out_free;
    logic        in_fire;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // one multiplier bit per cycle: add then shift the pair right
    assign mul_sum  = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mul_a_reg} : 33'd0);
    assign mul_prod = {mul_hi_reg, mul_lo_reg};

    // one quotient bit per cycle, restoring
    assign div_r2  = {div_rem_reg, div_quo_reg[47]};
    assign div_sub = {1'b0, div_r2} - {2'b00, div_d_reg};
    assign div_ge  = !div_sub[17];

    assign scale_abs = scale_reg[23] ? (~scale_reg + 24'd1) : scale_reg;

    // large steps saturate the integral either way, so cap the step first
    always_comb
    begin
        int_q       = (|div_quo_reg[47:25]) ? 26'h200_0000 : div_quo_reg[25:0];
        int_lim     = $signed(INT_LIMIT[27:0]);
        int_base    = $signed(integral_reg[27:0]);
        int_add     = err_reg[31] ? -$signed({2'b00, int_q}) : $signed({2'b00, int_q});
        int_acc     = int_base + int_add;
        if (int_acc > int_lim)
            int_clamped = int_lim;
        else if (int_acc < -int_lim)
            int_clamped = -int_lim;
        else
            int_clamped = int_acc;
    end

    assign term = neg_reg ? -$signed({3'b000, mul_prod[63:16]})
                          :  $signed({3'b000, mul_prod[63:16]});

    always_comb
    begin
        sum_mag  = sum_reg[50] ? 51'(-sum_reg) : 51'(sum_reg);
        pwm_mag  = sum_mag[49:16];
        pwm_nz   = |pwm_mag;
        duty_val = (pwm_mag >= 34'(DUTY_MAX)) ? 8'(DUTY_MAX) : pwm_mag[7:0];
        if (target_reg == 32'd0)
        begin
            emit    = 1'b1;
            out_dir = DIR_COAST;
        end
        else
        begin
            emit    = pwm_nz;
            // drive is the negated sum
            out_dir = sum_reg[50] ? DIR_FWD : DIR_REV;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = 6'd0;
        gain_p_next   = gain_p_reg;
        gain_i_next   = gain_i_reg;
        gain_d_next   = gain_d_reg;
        scale_next    = scale_reg;
        last_pos_next = last_pos_reg;
        last_err_next = last_err_reg;
        integral_next = integral_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        t_next        = t_reg;
        target_next   = target_reg;
        err_next      = err_reg;
        der_next      = der_reg;
        diff_next     = diff_reg;
        neg_next      = neg_reg;
        sum_next      = sum_reg;
        mul_a_next    = mul_a_reg;
        mul_hi_next   = mul_hi_reg;
        mul_lo_next   = mul_lo_reg;
        div_d_next    = div_d_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_P:    gain_p_next = cfg_data;
                REG_GAIN_I:    gain_i_next = cfg_data;
                REG_GAIN_D:    gain_d_next = cfg_data;
                REG_POS_SCALE: scale_next  = cfg_data[23:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    t_next      = (s_tdata[47:32] == 16'd0) ? 16'd1 : s_tdata[47:32];
                    target_next = s_tdata[79:48];
                    neg_next    = s_tdata[31] ^ scale_reg[23];
                    mul_a_next  = abs32(s_tdata[31:0]);
                    mul_hi_next = 32'd0;
                    mul_lo_next = {8'd0, scale_abs};
                    state_next  = S_MPOS;
                end
            end
            S_MPOS, S_MVEL, S_MINT, S_MDER, S_MGP, S_MGI, S_MGD:
            begin
                mul_hi_next = mul_sum[32:1];
                mul_lo_next = {mul_sum[0], mul_lo_reg[31:1]};
                step_next   = step_reg + 6'd1;
                if (step_reg == MUL_LAST)
                begin
                    step_next = 6'd0;
                    case (state_reg)
                        S_MPOS:  state_next = S_POS;
                        S_MVEL:  state_next = S_DVL;
                        S_MINT:  state_next = S_DIL;
                        S_MDER:  state_next = S_DDL;
                        S_MGP:   state_next = S_AGP;
                        S_MGI:   state_next = S_AGI;
                        default: state_next = S_AGD;
                    endcase
                end
            end
            S_DVEL, S_DINT, S_DDER:
            begin
                div_rem_next = div_ge ? div_sub[15:0] : div_r2[15:0];
                div_quo_next = {div_quo_reg[46:0], div_ge};
                step_next    = step_reg + 6'd1;
                if (step_reg == DIV_LAST)
                begin
                    step_next = 6'd0;
                    case (state_reg)
                        S_DVEL:  state_next = S_VEL;
                        S_DINT:  state_next = S_INT;
                        default: state_next = S_DER;
                    endcase
                end
            end
            S_POS:
            begin
                // park the old position, take the new one
                diff_next     = {last_pos_reg[31], last_pos_reg};
                last_pos_next = sat_mag(mul_prod[63:8], neg_reg);
                state_next    = S_DIFF;
            end
            S_DIFF:
            begin
                diff_next  = {last_pos_reg[31], last_pos_reg} - diff_reg;
                state_next = S_LVEL;
            end
            S_LVEL:
            begin
                neg_next    = diff_reg[32];
                mul_a_next  = abs33(diff_reg);
                mul_hi_next = 32'd0;
                mul_lo_next = {16'd0, MS_PER_S};
                state_next  = S_MVEL;
            end
            S_DVL, S_DIL, S_DDL:
            begin
                div_quo_next = mul_prod[47:0];
                div_rem_next = 16'd0;
                div_d_next   = (state_reg == S_DIL) ? MS_PER_S : t_reg;
                case (state_reg)
                    S_DVL:   state_next = S_DVEL;
                    S_DIL:   state_next = S_DINT;
                    default: state_next = S_DDER;
                endcase
            end
            S_VEL:
            begin
                // der holds the velocity until the error is formed
                der_next   = sat_mag({8'd0, div_quo_reg}, neg_reg);
                state_next = S_ERR;
            end
            S_ERR:
            begin
                err_next   = sat_sub(target_reg, der_reg);
                state_next = S_LINT;
            end
            S_LINT:
            begin
                mul_a_next    = abs32(err_reg);
                mul_hi_next   = 32'd0;
                mul_lo_next   = {16'd0, t_reg};
                diff_next     = {err_reg[31], err_reg} - {last_err_reg[31], last_err_reg};
                last_err_next = err_reg;
                state_next    = S_MINT;
            end
            S_INT:
            begin
                integral_next = {{4{int_clamped[27]}}, int_clamped};
                neg_next      = diff_reg[32];
                mul_a_next    = abs33(diff_reg);
                mul_hi_next   = 32'd0;
                mul_lo_next   = {16'd0, MS_PER_S};
                state_next    = S_MDER;
            end
            S_DER:
            begin
                der_next    = sat_mag({8'd0, div_quo_reg}, neg_reg);
                sum_next    = '0;
                neg_next    = err_reg[31];
                mul_a_next  = gain_p_reg;
                mul_hi_next = 32'd0;
                mul_lo_next = abs32(err_reg);
                state_next  = S_MGP;
            end
            S_AGP:
            begin
                sum_next    = sum_reg + term;
                neg_next    = integral_reg[31];
                mul_a_next  = gain_i_reg;
                mul_hi_next = 32'd0;
                mul_lo_next = abs32(integral_reg);
                state_next  = S_MGI;
            end
            S_AGI:
            begin
                sum_next    = sum_reg + term;
                neg_next    = der_reg[31];
                mul_a_next  = gain_d_reg;
                mul_hi_next = 32'd0;
                mul_lo_next = abs32(der_reg);
                state_next  = S_MGD;
            end
            S_AGD:
            begin
                sum_next   = sum_reg + term;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!emit)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0,
                                     (out_dir == DIR_COAST) ? 8'd0 : duty_val,
                                     out_dir};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= 6'd0;
            gain_p_reg   <= GAIN_P_RESET;
            gain_i_reg   <= GAIN_I_RESET;
            gain_d_reg   <= GAIN_D_RESET;
            scale_reg    <= SCALE_RESET;
            last_pos_reg <= 32'd0;
            last_err_reg <= 32'd0;
            integral_reg <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            gain_p_reg   <= gain_p_next;
            gain_i_reg   <= gain_i_next;
            gain_d_reg   <= gain_d_next;
            scale_reg    <= scale_next;
            last_pos_reg <= last_pos_next;
            last_err_reg <= last_err_next;
            integral_reg <= integral_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        t_reg       <= t_next;
        target_reg  <= target_next;
        err_reg     <= err_next;
        der_reg     <= der_next;
        diff_reg    <= diff_next;
        neg_reg     <= neg_next;
        sum_reg     <= sum_next;
        mul_a_reg   <= mul_a_next;
        mul_hi_reg  <= mul_hi_next;
        mul_lo_reg  <= mul_lo_next;
        div_d_reg   <= div_d_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
    end

    a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        abs32(integral_reg) <= INT_LIMIT)
        else $error("integral outside its clamp");

    a_coast_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[1:0] == DIR_COAST) |-> (m_tdata_reg[9:2] == 8'd0))
        else $error("coast item with nonzero duty");

    a_drive_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[1:0] != DIR_COAST)
            |-> ((m_tdata_reg[1:0] == DIR_FWD || m_tdata_reg[1:0] == DIR_REV)
                 && m_tdata_reg[9:2] != 8'd0))
        else $error("drive item with bad direction or zero duty");

    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_MPOS && step_reg == 6'd0))
        else $error("accepted item did not start the position product");

endmodule
